/* hw/rtl/sac_pkg.sv */
`default_nettype none
package sac_pkg;

  // default geometry
  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_ADDR_WIDTH   = 64;

  // field widths fixed by the interface
  localparam int SET_BITS_W  = 3;
  localparam int OFFSET_W    = 6;
  localparam int WAYS_CFG_W  = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int OUTCOME_W   = 2;
  localparam int OUT_SET_W   = 6;
  localparam int OUT_WAY_W   = 3;
  localparam int CNT_W       = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

  // outcome codes
  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_WRITE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;   // write a zero row at the sweep pointer
    logic load;    // capture set and tag of the accepted address
    logic rd_en;   // read the set row
    logic eval;    // register lookup decision
    logic commit;  // write back row, update totals, emit result
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
  } dp_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/sac_ram.sv */
`default_nettype none
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port; read data holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sac_ctrl.sv */
`default_nettype none
module sac_ctrl
  import sac_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire dp_sts_t  sts,
  output ctl_cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_READ:  cmd.rd_en  = 1'b1;
      ST_EVAL:  cmd.eval   = 1'b1;
      ST_WRITE: cmd.commit = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/sac_dp.sv */
`default_nettype none
module sac_dp
  import sac_pkg::*;
#(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire ctl_cmd_t               cmd,
  output dp_sts_t                     sts,
  input  wire logic [ADDR_WIDTH-1:0]  in_address,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                        out_valid,
  output logic [OUTCOME_W-1:0]        out_outcome,
  output logic [OUT_SET_W-1:0]        out_set_number,
  output logic [OUT_WAY_W-1:0]        out_way_used,
  output logic [CNT_W-1:0]            out_hit_total,
  output logic [CNT_W-1:0]            out_miss_total,
  output logic [CNT_W-1:0]            out_eviction_total
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W   = WAY_W;
  localparam int LIM_W    = RANK_W + 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int LINE_W   = 1 + ADDR_WIDTH + RANK_W;
  localparam int ROW_W    = LINE_W * MAX_WAYS;
  localparam int TSH_W    = OFFSET_W + 1;

  // configuration registers
  logic [SET_BITS_W-1:0] set_bits_r;
  logic [OFFSET_W-1:0]   offset_bits_r;
  logic [WAYS_CFG_W-1:0] ways_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= '0;
      offset_bits_r <= '0;
      ways_cfg_r    <= WAYS_CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:    set_bits_r    <= cfg_data[SET_BITS_W-1:0];
        CFG_OFFSET_BITS: offset_bits_r <= cfg_data[OFFSET_W-1:0];
        CFG_WAYS:        ways_cfg_r    <= cfg_data[WAYS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [SET_BITS_W-1:0] set_bits_eff;
  logic [WCNT_W-1:0]     ways_eff;

  always_comb begin
    set_bits_eff = (int'(set_bits_r) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS) : set_bits_r;
    if (ways_cfg_r == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(ways_cfg_r) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_cfg_r);
    end
  end

  // address split at accept
  logic [ADDR_WIDTH-1:0] off_shifted;
  logic [SET_AW-1:0]     set_mask;
  logic [TSH_W-1:0]      tag_shift;
  logic [SET_AW-1:0]     set_r;
  logic [ADDR_WIDTH-1:0] tag_r;

  always_comb begin
    off_shifted = in_address >> offset_bits_r;
    set_mask    = ~({SET_AW{1'b1}} << set_bits_eff);
    tag_shift   = TSH_W'(set_bits_eff) + TSH_W'(offset_bits_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_r <= off_shifted[SET_AW-1:0] & set_mask;
      tag_r <= in_address >> tag_shift;
    end
  end

  // clearing sweep pointer
  logic [SET_AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + SET_AW'(1);
    end
  end

  assign sts.clear_last = (clr_cnt_r == SET_AW'(NUM_SETS - 1));

  // set row storage
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  wr_row;
  logic [SET_AW-1:0] wr_addr;

  assign wr_addr = cmd.clear ? clr_cnt_r : set_r;

  sac_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (cmd.clear | cmd.commit),
    .waddr (wr_addr),
    .wdata (cmd.clear ? '0 : wr_row),
    .re    (cmd.rd_en),
    .raddr (set_r),
    .rdata (rd_row)
  );

  // unpack the row
  logic                  ln_valid [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] ln_tag   [MAX_WAYS];
  logic [RANK_W-1:0]     ln_rank  [MAX_WAYS];

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      ln_valid[i] = rd_row[i*LINE_W];
      ln_tag[i]   = rd_row[i*LINE_W + 1 +: ADDR_WIDTH];
      ln_rank[i]  = rd_row[i*LINE_W + 1 + ADDR_WIDTH +: RANK_W];
    end
  end

  // lookup: first hit, first empty, oldest valid (first wins ties)
  logic                 hit_found, empty_found, have_valid;
  logic [WAY_W-1:0]     hit_way, empty_way, victim_way;
  logic [RANK_W-1:0]    victim_rank;
  logic [OUTCOME_W-1:0] outcome_nxt;
  logic [WAY_W-1:0]     way_nxt;
  logic [LIM_W-1:0]     limit_nxt;

  always_comb begin
    hit_found   = 1'b0;
    empty_found = 1'b0;
    have_valid  = 1'b0;
    hit_way     = '0;
    empty_way   = '0;
    victim_way  = '0;
    victim_rank = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WCNT_W'(i) < ways_eff) begin
        if (ln_valid[i]) begin
          if (ln_tag[i] == tag_r && !hit_found) begin
            hit_found = 1'b1;
            hit_way   = WAY_W'(i);
          end
          if (!have_valid || ln_rank[i] > victim_rank) begin
            have_valid  = 1'b1;
            victim_rank = ln_rank[i];
            victim_way  = WAY_W'(i);
          end
        end else if (!empty_found) begin
          empty_found = 1'b1;
          empty_way   = WAY_W'(i);
        end
      end
    end

    if (hit_found) begin
      outcome_nxt = OUTCOME_HIT;
      way_nxt     = hit_way;
      limit_nxt   = LIM_W'(ln_rank[hit_way]);
    end else if (empty_found) begin
      outcome_nxt = OUTCOME_FILL;
      way_nxt     = empty_way;
      limit_nxt   = LIM_W'(MAX_WAYS);
    end else begin
      outcome_nxt = OUTCOME_EVICT;
      way_nxt     = victim_way;
      limit_nxt   = LIM_W'(victim_rank);
    end
  end

  logic [OUTCOME_W-1:0] outcome_r;
  logic [WAY_W-1:0]     way_r;
  logic [LIM_W-1:0]     limit_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      outcome_r <= outcome_nxt;
      way_r     <= way_nxt;
      limit_r   <= limit_nxt;
    end
  end

  // write-back row: touched way to rank 0, younger valid ways age by one
  always_comb begin
    wr_row = rd_row;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WCNT_W'(i) < ways_eff) begin
        if (WAY_W'(i) == way_r) begin
          wr_row[i*LINE_W]                       = 1'b1;
          wr_row[i*LINE_W + 1 +: ADDR_WIDTH]     = tag_r;
          wr_row[i*LINE_W + 1 + ADDR_WIDTH +: RANK_W] = '0;
        end else if (ln_valid[i] && (LIM_W'(ln_rank[i]) < limit_r) &&
                     (int'(ln_rank[i]) < MAX_WAYS - 1)) begin
          wr_row[i*LINE_W + 1 + ADDR_WIDTH +: RANK_W] = ln_rank[i] + RANK_W'(1);
        end
      end
    end
  end

  // saturating totals
  logic [CNT_W-1:0] hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [CNT_W-1:0] hit_cnt_nxt, miss_cnt_nxt, evict_cnt_nxt;

  always_comb begin
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    if (outcome_r == OUTCOME_HIT) begin
      if (hit_cnt_r != '1) hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
    end else begin
      if (miss_cnt_r != '1) miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
      if (outcome_r == OUTCOME_EVICT && evict_cnt_r != '1) begin
        evict_cnt_nxt = evict_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else if (cmd.commit) begin
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
    end
  end

  // result register, one-cycle strobe
  logic                 out_valid_r;
  logic [OUTCOME_W-1:0] out_outcome_r;
  logic [OUT_SET_W-1:0] out_set_r;
  logic [OUT_WAY_W-1:0] out_way_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_outcome_r <= outcome_r;
      out_set_r     <= OUT_SET_W'(set_r);
      out_way_r     <= OUT_WAY_W'(way_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_outcome        = out_outcome_r;
  assign out_set_number     = out_set_r;
  assign out_way_used       = out_way_r;
  assign out_hit_total      = hit_cnt_r;
  assign out_miss_total     = miss_cnt_r;
  assign out_eviction_total = evict_cnt_r;

endmodule
`default_nettype wire

/* hw/rtl/set_assoc_cache_lru_lookup.sv */
// Set-associative cache lookup with LRU replacement. An address is accepted
// when start is high and busy is low; busy then stays high for the lookup,
// which reads the set row from the row RAM, picks hit, fill or victim, and
// writes the row back; a new address is taken only once that read, decide
// and write-back sequence on the single row RAM is done. The result appears
// on the out_ ports for exactly one cycle, marked by out_valid, in the cycle
// after the write-back; the receiver cannot stall it, so it must take every
// beat as it comes. After reset the block sweeps the row RAM clear, one set
// per cycle, through all 2**MAX_SET_BITS sets (64 by default) with busy high;
// configuration writes are taken at any time (cfg_ready is always high) but
// should only be issued while the block is idle.
`default_nettype none
module set_assoc_cache_lru_lookup
  import sac_pkg::*;
#(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [ADDR_WIDTH-1:0]  in_address,
  output logic                        out_valid,
  output logic [OUTCOME_W-1:0]        out_outcome,
  output logic [OUT_SET_W-1:0]        out_set_number,
  output logic [OUT_WAY_W-1:0]        out_way_used,
  output logic [CNT_W-1:0]            out_hit_total,
  output logic [CNT_W-1:0]            out_miss_total,
  output logic [CNT_W-1:0]            out_eviction_total,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  assign cfg_ready = 1'b1;

  sac_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sac_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_address         (in_address),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_outcome        (out_outcome),
    .out_set_number     (out_set_number),
    .out_way_used       (out_way_used),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total)
  );

endmodule
`default_nettype wire

/* bench/tb_set_assoc_cache_lru_lookup.sv */
`timescale 1ns / 100ps

module tb_set_assoc_cache_lru_lookup
  import sac_pkg::*;
();

  localparam int NSETS  = 1 << DEF_MAX_SET_BITS;
  localparam int NWAYS  = DEF_MAX_WAYS;
  localparam int RANK_W = $clog2(DEF_MAX_WAYS);
  // index 3 maps to no register; writes there must leave the settings alone
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 80;

  typedef struct packed {
    logic [OUTCOME_W-1:0]  outcome;
    logic [OUT_SET_W-1:0]  set_number;
    logic [OUT_WAY_W-1:0]  way_used;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      miss_total;
    logic [CNT_W-1:0]      eviction_total;
  } lookup_result_t;

  typedef enum logic [0:0] {ROW_CFG, ROW_LOOKUP} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [63:0]            value;   // address, or write data for a register row
    logic [CFG_IDX_W-1:0]   index;
    logic                   typed;   // expected result given by hand
    lookup_result_t         result;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [DEF_ADDR_WIDTH-1:0] in_address;
  logic                     out_valid;
  logic [OUTCOME_W-1:0]     out_outcome;
  logic [OUT_SET_W-1:0]     out_set_number;
  logic [OUT_WAY_W-1:0]     out_way_used;
  logic [CNT_W-1:0]         out_hit_total;
  logic [CNT_W-1:0]         out_miss_total;
  logic [CNT_W-1:0]         out_eviction_total;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  // hand-typed expectation travelling with the beat being offered
  logic                     typed_pending;
  lookup_result_t           typed_value;

  // mirror of the cache state
  bit                       mdl_valid [NSETS*NWAYS];
  bit [63:0]                mdl_tag   [NSETS*NWAYS];
  bit [RANK_W-1:0]          mdl_rank  [NSETS*NWAYS];
  bit [CNT_W-1:0]           mdl_hits;
  bit [CNT_W-1:0]           mdl_misses;
  bit [CNT_W-1:0]           mdl_evicts;
  bit [SET_BITS_W-1:0]      reg_set_bits = '0;
  bit [OFFSET_W-1:0]        reg_offset   = '0;
  bit [WAYS_CFG_W-1:0]      reg_ways     = WAYS_CFG_W'(1);

  lookup_result_t           pending_lookups[$];
  int                       errors;
  int                       checked_total;
  int                       seen_hits;
  int                       seen_fills;
  int                       seen_evicts;
  int                       cfg_writes;
  bit                       no_idle;

  set_assoc_cache_lru_lookup DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_outcome        (out_outcome),
    .out_set_number     (out_set_number),
    .out_way_used       (out_way_used),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit [CNT_W-1:0] sat_bump(input bit [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Lookup with LRU ranks: rank 0 is newest, ranks saturate at NWAYS-1.
  function automatic lookup_result_t predict_lookup(input logic [63:0] addr);
    int i, k, s, ways, base, hit_way, empty_way, victim, way;
    int unsigned set_idx, shift, limit, victim_rank;
    bit have_valid;
    bit [63:0] tag;
    lookup_result_t r;
    s = (reg_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : 32'(reg_set_bits);
    ways = (reg_ways == 0) ? 1 : ((reg_ways > NWAYS) ? NWAYS : 32'(reg_ways));
    set_idx = int'((addr >> reg_offset) & ((64'd1 << s) - 64'd1));
    shift = s + 32'(reg_offset);
    tag = (shift >= 64) ? 64'd0 : (addr >> shift);
    base = set_idx * NWAYS;
    hit_way = -1;
    empty_way = -1;
    victim = 0;
    victim_rank = 0;
    have_valid = 1'b0;
    for (i = 0; i < ways; i++) begin
      k = base + i;
      if (mdl_valid[k]) begin
        if (mdl_tag[k] == tag) begin
          hit_way = i;
          break;
        end
        if (!have_valid || mdl_rank[k] > victim_rank) begin
          have_valid = 1'b1;
          victim_rank = 32'(mdl_rank[k]);
          victim = i;
        end
      end else if (empty_way < 0) begin
        empty_way = i;
      end
    end

    if (hit_way >= 0) begin
      way = hit_way;
      r.outcome = OUTCOME_HIT;
      mdl_hits = sat_bump(mdl_hits);
      limit = 32'(mdl_rank[base + way]);
    end else begin
      mdl_misses = sat_bump(mdl_misses);
      if (empty_way >= 0) begin
        way = empty_way;
        r.outcome = OUTCOME_FILL;
        mdl_valid[base + way] = 1'b1;
        limit = NWAYS;
      end else begin
        way = victim;
        r.outcome = OUTCOME_EVICT;
        mdl_evicts = sat_bump(mdl_evicts);
        limit = victim_rank;
      end
      mdl_tag[base + way] = tag;
    end

    // age the ways that were newer than the touched one
    for (i = 0; i < ways; i++) begin
      k = base + i;
      if (i != way && mdl_valid[k] && mdl_rank[k] < limit && mdl_rank[k] < NWAYS - 1)
        mdl_rank[k] = mdl_rank[k] + 1'b1;
    end
    mdl_rank[base + way] = '0;

    r.set_number     = OUT_SET_W'(set_idx);
    r.way_used       = OUT_WAY_W'(way);
    r.hit_total      = mdl_hits;
    r.miss_total     = mdl_misses;
    r.eviction_total = mdl_evicts;
    return r;
  endfunction

  function automatic string fmt_result(input lookup_result_t r);
    return $sformatf("outcome=%0d set=%0d way=%0d hits=%0d misses=%0d evictions=%0d",
                     r.outcome, r.set_number, r.way_used, r.hit_total, r.miss_total,
                     r.eviction_total);
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10)
      $display("[%0t] ERROR: %s", $time, msg);
  endtask

  // Scoreboard: check result beats, then log accepted lookups and register writes.
  always @(posedge clk) begin : scoreboard
    lookup_result_t got, want, pred;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) begin
        got.outcome        = out_outcome;
        got.set_number     = out_set_number;
        got.way_used       = out_way_used;
        got.hit_total      = out_hit_total;
        got.miss_total     = out_miss_total;
        got.eviction_total = out_eviction_total;
        if (pending_lookups.size() == 0) begin
          flag_error({"result beat with nothing outstanding: ", fmt_result(got)});
        end else begin
          want = pending_lookups.pop_front();
          checked_total++;
          if (got !== want)
            flag_error({"result mismatch\n  expected ", fmt_result(want),
                        "\n  actual   ", fmt_result(got)});
          case (got.outcome)
            OUTCOME_HIT:   seen_hits++;
            OUTCOME_FILL:  seen_fills++;
            OUTCOME_EVICT: seen_evicts++;
            default: ;
          endcase
        end
      end

      if (start === 1'b1 && busy === 1'b0) begin
        pred = predict_lookup(in_address);
        pending_lookups.push_back(typed_pending ? typed_value : pred);
      end

      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          CFG_SET_BITS:    reg_set_bits = cfg_data[SET_BITS_W-1:0];
          CFG_OFFSET_BITS: reg_offset   = cfg_data[OFFSET_W-1:0];
          CFG_WAYS:        reg_ways     = cfg_data[WAYS_CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // mostly short gaps, a few long ones, none at all in burst phases
  function automatic int idle_cycles();
    int roll;
    if (no_idle)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return 0;
    else if (roll < 90)
      return $urandom_range(1, 3);
    else if (roll < 97)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 60);
  endfunction

  // offer one address, hold it until taken, then idle for a while
  task automatic issue_lookup(input logic [63:0] a, input logic typed,
                              input lookup_result_t want);
    int gap;
    start         <= 1'b1;
    in_address    <= a;
    typed_pending <= typed;
    typed_value   <= want;
    do @(posedge clk); while (busy !== 1'b0);
    gap = idle_cycles();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) begin
        in_address <= {$urandom, $urandom};
        @(posedge clk);
      end
    end
  endtask

  // sampled at the falling edge so the check never races the scoreboard
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (pending_lookups.size() != 0 || busy !== 1'b0)
      @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic stim_row_t lookup_row(input logic [63:0] a);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_LOOKUP;
    r.value = a;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [63:0] a, input logic [OUTCOME_W-1:0] oc,
                                          input int set_n, input int way_n,
                                          input int h, input int m, input int e);
    stim_row_t r;
    r = lookup_row(a);
    r.typed                 = 1'b1;
    r.result.outcome        = oc;
    r.result.set_number     = OUT_SET_W'(set_n);
    r.result.way_used       = OUT_WAY_W'(way_n);
    r.result.hit_total      = CNT_W'(h);
    r.result.miss_total     = CNT_W'(m);
    r.result.eviction_total = CNT_W'(e);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_CFG;
    r.index = idx;
    r.value = 64'(data);
    return r;
  endfunction

  // Stimulus: directed table, then random phases, each with its own geometry.
  initial begin : stimulus
    stim_row_t rows[$];
    bit [63:0] tag_pool[$];
    int set_pool[$];
    int phase, item, t, roll, sb, s_eff, o, wy, w_eff, n_tags, n_sets;
    logic [63:0] a;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_address    = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_SET_BITS;
    cfg_data      = '0;
    typed_pending = 1'b0;
    typed_value   = '0;
    no_idle       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: one set, one way, whole address is the tag
    rows.push_back(typed_row(64'd0, OUTCOME_FILL, 0, 0, 0, 1, 0));
    rows.push_back(typed_row(64'd0, OUTCOME_HIT, 0, 0, 1, 1, 0));
    rows.push_back(typed_row('1, OUTCOME_EVICT, 0, 0, 1, 2, 1));
    rows.push_back(typed_row('1, OUTCOME_HIT, 0, 0, 2, 2, 1));
    // zero ways behaves as one way
    rows.push_back(cfg_row(CFG_WAYS, 6'd0));
    rows.push_back(typed_row(64'd0, OUTCOME_EVICT, 0, 0, 2, 3, 2));
    // set bits above the maximum clamp; set plus offset past the address, tag is zero
    rows.push_back(cfg_row(CFG_SET_BITS, 6'd7));
    rows.push_back(cfg_row(CFG_OFFSET_BITS, 6'd63));
    rows.push_back(lookup_row(64'h8000_0000_0000_0000));
    rows.push_back(lookup_row(64'h0000_0000_0000_0000));
    rows.push_back(lookup_row(64'h7FFF_FFFF_FFFF_FFFF));
    // junk in the unused data bits; ways above the maximum clamp to eight
    rows.push_back(cfg_row(CFG_SET_BITS, 6'h3E));
    rows.push_back(cfg_row(CFG_OFFSET_BITS, 6'd0));
    rows.push_back(cfg_row(CFG_WAYS, 6'h3F));
    // fill one set, touch the oldest, then evict twice in LRU order
    for (t = 1; t <= 8; t++)
      rows.push_back(lookup_row((64'(t) << 6) | 64'd5));
    rows.push_back(lookup_row((64'd1 << 6) | 64'd5));
    rows.push_back(lookup_row((64'd9 << 6) | 64'd5));
    rows.push_back(lookup_row((64'd2 << 6) | 64'd5));
    // offset of 32 with no set bits
    rows.push_back(cfg_row(CFG_SET_BITS, 6'd0));
    rows.push_back(cfg_row(CFG_OFFSET_BITS, 6'd32));
    rows.push_back(lookup_row(64'hFFFF_FFFF_0000_0000));
    rows.push_back(lookup_row(64'hFFFF_FFFF_1234_5678));
    rows.push_back(cfg_row(CFG_UNMAPPED, 6'h2A));
    // set plus offset exactly the address width
    rows.push_back(cfg_row(CFG_SET_BITS, 6'd6));
    rows.push_back(cfg_row(CFG_OFFSET_BITS, 6'd58));
    rows.push_back(lookup_row(64'hFC00_0000_0000_0000));
    rows.push_back(lookup_row(64'h03FF_FFFF_FFFF_FFFF));

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG)
        write_register(rows[r].index, rows[r].value[CFG_DATA_W-1:0]);
      else
        issue_lookup(rows[r].value, rows[r].typed, rows[r].result);
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      sb = $urandom_range(0, 7);
      o  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(0, 63);
      wy = $urandom_range(0, 15);
      write_register(CFG_SET_BITS, {3'($urandom), 3'(sb)});
      write_register(CFG_OFFSET_BITS, 6'(o));
      write_register(CFG_WAYS, {2'($urandom), 4'(wy)});
      if ($urandom_range(0, 3) == 0)
        write_register(CFG_UNMAPPED, 6'($urandom));
      s_eff = (sb > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : sb;
      w_eff = (wy == 0) ? 1 : ((wy > NWAYS) ? NWAYS : wy);
      no_idle = ($urandom_range(0, 3) == 0);

      // small pools of tags and sets so that hits and evictions are common
      tag_pool.delete();
      set_pool.delete();
      n_tags = $urandom_range(1, w_eff + 3);
      n_sets = $urandom_range(1, 3);
      repeat (n_tags) tag_pool.push_back({$urandom, $urandom});
      repeat (n_sets) set_pool.push_back($urandom_range(0, NSETS - 1));

      for (item = 0; item < PHASE_ITEMS; item++) begin
        roll = $urandom_range(0, 99);
        if (roll < 80)
          a = (tag_pool[$urandom_range(0, n_tags - 1)] << (s_eff + o))
              | (64'(set_pool[$urandom_range(0, n_sets - 1)]) << o)
              | ({$urandom, $urandom} & ((64'd1 << o) - 64'd1));
        else
          a = {$urandom, $urandom};
        issue_lookup(a, 1'b0, '0);
      end
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Checked %0d lookups: %0d hits, %0d fills, %0d evictions.",
             checked_total, seen_hits, seen_fills, seen_evicts);
    $display("%0d register writes over %0d random geometries; %0d errors.",
             cfg_writes, RANDOM_PHASES, errors);
    if (errors == 0) begin
      $display("** set_assoc_cache_lru_lookup: PASSED **");
    end else begin
      $display("** set_assoc_cache_lru_lookup: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #10_000_000;
    $display("Timeout with %0d lookups still outstanding.", pending_lookups.size());
    $display("** set_assoc_cache_lru_lookup: FAILED **");
    $finish;
  end

endmodule
